// ===== design/etmr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, reset values, register indexes and scaling constants
// for the echo time median ranger. No dependencies.
package etmr_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned ECHO_W   = 20;
  localparam int unsigned MARGIN_W = 16;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned RING_DEPTH = 3;
  localparam int unsigned POS_W      = 2;

  // Echo time to millimetres: delta * 343 / 2000, done as a multiply by
  // ceil(343 * 2^31 / 2000) and a shift by 31. Exact for any 20-bit delta.
  localparam int unsigned MULT_W  = 29;
  localparam int unsigned SHIFT   = 31;
  localparam int unsigned PROD_W  = ECHO_W + MULT_W;
  localparam int unsigned QUOT_W  = PROD_W - SHIFT;
  localparam logic [MULT_W-1:0] MM_MULT = 29'd368293446;

  localparam logic [ECHO_W-1:0]   MAX_ECHO_RST     = 20'd2623;
  localparam logic [MARGIN_W-1:0] STALE_MARGIN_RST = 16'd200;
  localparam logic [DIST_W-1:0]   MIN_DIST_RST     = 16'd30;
  localparam logic [DIST_W-1:0]   MAX_DIST_RST     = 16'd450;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ECHO     = 8'd0,
    REG_STALE_MARGIN = 8'd1,
    REG_MIN_DIST     = 8'd2,
    REG_MAX_DIST     = 8'd3
  } cfg_reg_e;

  typedef logic [DIST_W-1:0] dist_t;

endpackage

// ===== design/echo_time_median_ranger_top.sv =====
`timescale 1ns / 1ps
// Top level of the echo time median ranger: edge events in, filtered distances out.
// Depends on etmr_pkg and etmr_dist_conv.
//
// Usage:
//   s_axis carries one echo-pin edge per item: tuser[0] is the level after the
//   edge (1 rising, 0 falling), tdata[63:0] the edge time in microseconds.
//   m_axis carries one distance in millimetres per item on tdata[15:0]: the
//   median of the last three kept echoes, clipped to the configured bounds.
//   Rising edges, unmatched or stale falling edges, too-long echoes and the
//   first two kept echoes give no output item.
//   cfg writes one of four registers (index 0..3: max echo time, stale margin,
//   min distance, max distance); other indexes are ignored. cfg_ready_o is
//   always high. Write only while no item is in flight.
// Pipeline and throughput:
//   An accepted item is evaluated from the input register and its result is
//   held in the output register for m_axis. One item per cycle is taken while
//   m_axis is not stalled; the single combinational pass (64-bit compare, one
//   constant multiply, median and clip) sets the clock, not the rate.
// Reset: config returns to its defaults, the held rise and the ring are
//   cleared, so three kept echoes are needed before the first output.
// Stall: a result waiting on m_axis holds; one more item is taken into the
//   input register, then s_axis_tready_o drops until the result is taken.
module echo_time_median_ranger_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [63:0]                    s_axis_tdata_i,  // [63:0] edge_time_us
  input  logic [0:0]                     s_axis_tuser_i,  // [0] edge_level
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [15:0]                    m_axis_tdata_o,  // [15:0] range_mm
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [etmr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [etmr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import etmr_pkg::*;

  // configuration
  logic [ECHO_W-1:0]   max_echo_q;
  logic [MARGIN_W-1:0] margin_q;
  dist_t               min_dist_q;
  dist_t               max_dist_q;

  // input register
  logic              in_valid_q;
  logic              in_level_q;
  logic [TIME_W-1:0] in_time_q;

  // ranging state
  logic [TIME_W-1:0] rise_time_q, rise_time_d;
  logic              rise_held_q, rise_held_d;
  dist_t             ring_q [RING_DEPTH];
  dist_t             ring_d [RING_DEPTH];
  logic [POS_W-1:0]  wr_pos_q, wr_pos_d;
  logic [POS_W-1:0]  fill_q, fill_d;

  // output register
  logic  out_valid_q, out_valid_d;
  dist_t out_data_q;

  logic              out_free;
  logic              advance;
  logic              in_accept;
  logic [TIME_W:0]   diff_ext;
  logic [TIME_W-1:0] diff;
  logic              later;
  logic [ECHO_W:0]   stale_lim;
  logic              stale;
  logic              held_eff;
  logic              fall_ok;
  logic              fits;
  logic              keep;
  logic              emit;
  dist_t             conv_mm;
  dist_t             lo, hi, hi_c, med, med_lo, med_clip;

  // handshake: the input register moves on whenever the output register is
  // empty or being emptied in this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // echo gap; "later" means the edge time is strictly after the held rise
  assign diff_ext = {1'b0, in_time_q} - {1'b0, rise_time_q};
  assign diff     = diff_ext[TIME_W-1:0];
  assign later    = !diff_ext[TIME_W] && (diff != '0);

  // drop a held rise that is older than max echo plus margin
  assign stale_lim = {1'b0, max_echo_q} + {{(ECHO_W + 1 - MARGIN_W){1'b0}}, margin_q};
  assign stale     = rise_held_q && later &&
                     (diff > {{(TIME_W - ECHO_W - 1){1'b0}}, stale_lim});
  assign held_eff  = rise_held_q && !stale;

  assign fall_ok = !in_level_q && held_eff && later;
  assign fits    = (diff[TIME_W-1:ECHO_W] == '0) && (diff[ECHO_W-1:0] <= max_echo_q);
  assign keep    = fall_ok && fits;
  // result only once the ring holds three distances, counting this one
  assign emit    = keep && (fill_q >= POS_W'(RING_DEPTH - 1));

  etmr_dist_conv u_conv (
    .delta_i (diff[ECHO_W-1:0]),
    .dist_o  (conv_mm)
  );

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_d[i] = (keep && (wr_pos_q == POS_W'(i))) ? conv_mm : ring_q[i];
    end
  end

  // median of three on the updated ring, then clip low first, high second
  assign lo       = (ring_d[0] > ring_d[1]) ? ring_d[1] : ring_d[0];
  assign hi       = (ring_d[0] > ring_d[1]) ? ring_d[0] : ring_d[1];
  assign hi_c     = (hi > ring_d[2]) ? ring_d[2] : hi;
  assign med      = (lo > hi_c) ? lo : hi_c;
  assign med_lo   = (med < min_dist_q) ? min_dist_q : med;
  assign med_clip = (med_lo > max_dist_q) ? max_dist_q : med_lo;

  always_comb begin
    rise_time_d = rise_time_q;
    rise_held_d = rise_held_q;
    wr_pos_d    = wr_pos_q;
    fill_d      = fill_q;
    if (in_level_q) begin
      rise_time_d = in_time_q;
      rise_held_d = 1'b1;
    end else begin
      rise_held_d = held_eff && !fall_ok;
    end
    if (keep) begin
      wr_pos_d = (wr_pos_q >= POS_W'(RING_DEPTH - 1)) ? '0 : wr_pos_q + POS_W'(1);
      fill_d   = (fill_q >= POS_W'(RING_DEPTH)) ? fill_q : fill_q + POS_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rise_time_q <= '0;
      rise_held_q <= 1'b0;
      wr_pos_q    <= '0;
      fill_q      <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        rise_time_q <= rise_time_d;
        rise_held_q <= rise_held_d;
        wr_pos_q    <= wr_pos_d;
        fill_q      <= fill_d;
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_q[i] <= ring_d[i];
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_echo_q <= MAX_ECHO_RST;
      margin_q   <= STALE_MARGIN_RST;
      min_dist_q <= MIN_DIST_RST;
      max_dist_q <= MAX_DIST_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_ECHO:     max_echo_q <= cfg_data_i[ECHO_W-1:0];
        REG_STALE_MARGIN: margin_q   <= cfg_data_i[MARGIN_W-1:0];
        REG_MIN_DIST:     min_dist_q <= cfg_data_i[DIST_W-1:0];
        REG_MAX_DIST:     max_dist_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_level_q <= s_axis_tuser_i[0];
      in_time_q  <= s_axis_tdata_i;
    end
    if (advance && emit) begin
      out_data_q <= med_clip;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== design/etmr_dist_conv.sv =====
`timescale 1ns / 1ps
// Echo time to distance conversion with saturation to 16 bits.
// Depends on etmr_pkg.
module etmr_dist_conv (
  input  logic [etmr_pkg::ECHO_W-1:0] delta_i,
  output etmr_pkg::dist_t             dist_o
);
  import etmr_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  assign prod = {{MULT_W{1'b0}}, delta_i} * {{ECHO_W{1'b0}}, MM_MULT};
  assign quot = prod[PROD_W-1:SHIFT];

  // saturate anything that does not fit 16 bits
  assign dist_o = (|quot[QUOT_W-1:DIST_W]) ? {DIST_W{1'b1}} : quot[DIST_W-1:0];

endmodule

// ===== design/etmr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the echo time median ranger, bound to the top level.
// Depends on echo_time_median_ranger_top.
module etmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] credit_q, credit_d;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // items in flight never exceed two, so a saturating count of accepted
  // items minus delivered results stays nonzero whenever a result leaves
  always_comb begin
    credit_d = credit_q;
    if (in_acc && (credit_d != 2'd3)) begin
      credit_d = credit_d + 2'd1;
    end
    if (out_acc && (credit_d != 2'd0)) begin
      credit_d = credit_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= 2'd0;
    end else begin
      credit_q <= credit_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result shown right after reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (credit_q != 2'd0) || in_acc)
    else $error("result delivered without an accepted item");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while no result is pending");

endmodule

bind echo_time_median_ranger_top etmr_checker u_etmr_checker (.*);
